// File: rtl/hpe_pkg.sv
// Shared types and constants of the histogram percentile unit.
package hpe_pkg;

  localparam int unsigned NumBinsDef    = 1000;
  localparam int unsigned QueueDepthDef = 2;

  localparam int unsigned SampleW  = 12;
  localparam int unsigned PctW     = 10;
  localparam int unsigned ResW     = 10;
  localparam int unsigned TotW     = 32;
  localparam int unsigned CntW     = 16;
  localparam int unsigned ProdW    = TotW + PctW;
  localparam int unsigned MaxBinW  = 12;
  localparam int unsigned PctScale = 1000;

  typedef enum logic [0:0] {
    OP_RECORD = 1'b0,
    OP_QUERY  = 1'b1
  } hpe_op_e;

  typedef struct packed {
    hpe_op_e              op;
    logic [MaxBinW-1:0]   bin;
    logic [TotW-1:0]      total;
    logic [ProdW-1:0]     prod;
  } hpe_entry_t;

endpackage

// File: rtl/hpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hpe_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1000,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/hpe_front.sv
// Front end: accept beats, drop negative samples, clamp bins, form the query product.
module hpe_front import hpe_pkg::*; #(
  parameter int unsigned NumBins = NumBinsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hpe_op_e            req_type_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic [PctW-1:0]    pct_i,
  input  logic               block_i,
  input  logic               full_i,
  output logic               push_o,
  output hpe_entry_t         entry_o
);

  localparam logic [MaxBinW-1:0] LastBin = MaxBinW'(NumBins - 1);

  logic [TotW-1:0]    total_q, total_d;
  logic               accept;
  logic               negative;
  logic [MaxBinW-1:0] mag;
  logic [MaxBinW-1:0] bin_raw;

  assign in_ready_o = !full_i && !block_i;
  assign accept     = in_valid_i && in_ready_o;
  assign negative   = sample_i[SampleW-1];

  always_comb begin
    mag     = {1'b0, sample_i[SampleW-2:0]};
    bin_raw = (mag == '0) ? '0 : mag - MaxBinW'(1);
    entry_o.op    = req_type_i;
    entry_o.bin   = (bin_raw > LastBin) ? LastBin : bin_raw;
    entry_o.total = total_q;
    entry_o.prod  = ProdW'(total_q) * ProdW'(pct_i);
  end

  // Negative samples are taken and dropped here; they never reach the queue.
  assign push_o = accept && !(req_type_i == OP_RECORD && negative);

  always_comb begin
    total_d = total_q;
    if (push_o && req_type_i == OP_RECORD) begin
      total_d = total_q + TotW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= total_d;
    end
  end

endmodule

// File: rtl/hpe_queue.sv
// Small FIFO of classified work between front and back end.
module hpe_queue import hpe_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW2 = $clog2(Depth + 1)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hpe_entry_t entry_i,
  output logic       full_o,
  output logic       valid_o,
  output hpe_entry_t entry_o,
  input  logic       pop_i
);

  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  hpe_entry_t       mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW2-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW2'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW2'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW2'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: rtl/hpe_back.sv
// Back end: bin clearing pass, record read-modify-write, percentile walk, result register.
module hpe_back import hpe_pkg::*; #(
  parameter int unsigned NumBins = NumBinsDef,
  localparam int unsigned AddrW = (NumBins > 1) ? $clog2(NumBins) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  hpe_entry_t       entry_i,
  output logic             pop_o,
  output logic             clearing_o,
  output logic             ram_we_o,
  output logic [AddrW-1:0] ram_waddr_o,
  output logic [CntW-1:0]  ram_wdata_o,
  output logic [AddrW-1:0] ram_raddr_o,
  input  logic [CntW-1:0]  ram_rdata_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ResW-1:0]  result_o,
  output logic [TotW-1:0]  total_o,
  output logic             empty_o
);

  localparam int unsigned CumW  = AddrW + CntW;
  localparam int unsigned CumkW = CumW + PctW;
  localparam int unsigned CmpW  = (CumkW > ProdW) ? CumkW : ProdW;
  localparam int unsigned CtW   = (CumW > TotW) ? CumW : TotW;
  localparam int unsigned IncW  = (AddrW + 1 > ResW) ? AddrW + 1 : ResW;
  localparam int unsigned NoHit = NumBins % (2 ** ResW);
  localparam logic [AddrW-1:0] LastIdx = AddrW'(NumBins - 1);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_REC_WR = 2'd2;
  localparam logic [1:0] ST_WALK   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [AddrW-1:0] bin_q, bin_d;
  logic [CumW-1:0]  cum_q, cum_d;
  logic [CumkW-1:0] cumk_q, cumk_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [TotW-1:0]  tot_q, tot_d;
  logic             emp_q, emp_d;
  logic [ResW-1:0]  res_q, res_d;
  logic             out_valid_q, out_valid_d;

  logic [CumW-1:0]  cum_next;
  logic [CumkW-1:0] cumk_next;
  logic [IncW-1:0]  idx_inc;
  logic             hit;
  logic             last;

  assign cum_next  = cum_q + CumW'(ram_rdata_i);
  assign cumk_next = cumk_q + CumkW'(ram_rdata_i) * CumkW'(PctScale);
  // cum > floor(total*p/1000) is the same as cum*1000 > total*p; the clamp
  // to total-1 turns into cum >= total.
  assign hit       = (CmpW'(cumk_next) > CmpW'(prod_q)) || (CtW'(cum_next) >= CtW'(tot_q));
  assign idx_inc   = IncW'(idx_q) + IncW'(1);
  assign last      = (idx_q == LastIdx);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    bin_d       = bin_q;
    cum_d       = cum_q;
    cumk_d      = cumk_q;
    prod_d      = prod_q;
    tot_d       = tot_q;
    emp_d       = emp_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = '0;
    ram_raddr_o = '0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_q;
        if (last) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + AddrW'(1);
        end
      end
      ST_IDLE: begin
        if (valid_i) begin
          if (entry_i.op == OP_RECORD) begin
            pop_o       = 1'b1;
            ram_raddr_o = entry_i.bin[AddrW-1:0];
            bin_d       = entry_i.bin[AddrW-1:0];
            state_d     = ST_REC_WR;
          end else if (!out_valid_q) begin
            pop_o  = 1'b1;
            tot_d  = entry_i.total;
            prod_d = entry_i.prod;
            emp_d  = (entry_i.total == '0);
            if (entry_i.total == '0) begin
              res_d       = '0;
              out_valid_d = 1'b1;
            end else begin
              ram_raddr_o = '0;
              idx_d       = '0;
              cum_d       = '0;
              cumk_d      = '0;
              state_d     = ST_WALK;
            end
          end
        end
      end
      ST_REC_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = bin_q;
        ram_wdata_o = ram_rdata_i + CntW'(1);
        state_d     = ST_IDLE;
      end
      ST_WALK: begin
        cum_d       = cum_next;
        cumk_d      = cumk_next;
        ram_raddr_o = last ? '0 : idx_q + AddrW'(1);
        if (hit) begin
          res_d       = idx_inc[ResW-1:0];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else if (last) begin
          res_d       = ResW'(NoHit);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          idx_d = idx_q + AddrW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    cum_q  <= cum_d;
    cumk_q <= cumk_d;
    prod_q <= prod_d;
    tot_q  <= tot_d;
    emp_q  <= emp_d;
    res_q  <= res_d;
  end

  assign clearing_o  = (state_q == ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;
  assign total_o     = tot_q;
  assign empty_o     = emp_q;

`ifndef SYNTHESIS
  a_walk_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> !out_valid_q)
    else $error("walk running while a result is still pending");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (state_q == ST_CLEAR || state_q == ST_REC_WR))
    else $error("bin write outside clear or record update");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE && valid_i))
    else $error("queue popped outside idle");

  a_rec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REC_WR) |=> (state_q == ST_IDLE))
    else $error("record update took more than one write cycle");
`endif

endmodule

// File: rtl/histogram_percentile_unit.sv
// Histogram percentile unit: sample histogram with percentile queries.
//
// The unit keeps NUM_BINS 16-bit bin counters in one RAM (bin i holds samples
// of value i+1 tenths of a percent) and a 32-bit sample total. A beat with
// tuser = 0 records a sample: negative samples are dropped, zero lands in the
// first bin, anything past the last bin lands in the last one; bins wrap at
// 16 bits. A beat with tuser = 1 asks for percentile p (tenths of a percent)
// and yields one result beat; records yield none. Timing: a record holds the
// back end for a read and then a write of the bin RAM. A query on an empty
// histogram reads no bins; otherwise it walks the bins one RAM read per cycle,
// stopping at the first bin whose running sum passes the target. The single
// read port of the bin RAM sets that walk rate. A two-entry queue parts the
// front end from the back end, so beats are taken while a walk runs until the
// queue fills, and a pending result in the output register holds back only a
// query at the head of the queue and the work behind it. After reset the unit
// clears the bin RAM one entry per cycle with s_axis_tready low.
module histogram_percentile_unit import hpe_pkg::*; #(
  parameter int unsigned NUM_BINS = NumBinsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [11:0] sample_tenths, [21:12] percentile_tenths
  input  logic        s_axis_tuser_i,   // [0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [9:0] result_tenths, [41:10] sample_total
  output logic        m_axis_tuser_o    // [0] is_empty
);

  localparam int unsigned AddrW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  logic             push;
  hpe_entry_t       push_entry;
  logic             q_full;
  logic             q_valid;
  hpe_entry_t       q_entry;
  logic             pop;
  logic             clearing;
  hpe_op_e          req_type;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [CntW-1:0]  ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [CntW-1:0]  ram_rdata;

  logic [ResW-1:0]  result;
  logic [TotW-1:0]  total;
  logic             empty;

  assign req_type = hpe_op_e'(s_axis_tuser_i);

  // Classify beats and build queue entries.
  hpe_front #(
    .NumBins (NUM_BINS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .req_type_i (req_type),
    .sample_i   (s_axis_tdata_i[SampleW-1:0]),
    .pct_i      (s_axis_tdata_i[SampleW+PctW-1:SampleW]),
    .block_i    (clearing),
    .full_i     (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Hold work between the two halves.
  hpe_queue #(
    .Depth (QueueDepthDef)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_entry),
    .pop_i   (pop)
  );

  // Execute records and queries against the bin RAM.
  hpe_back #(
    .NumBins (NUM_BINS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (q_entry),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (result),
    .total_o     (total),
    .empty_o     (empty)
  );

  hpe_ram #(
    .Width (CntW),
    .Depth (NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Pack the result beat; pad the upper bits with zeros.
  assign m_axis_tdata_o = {6'b0, total, result};
  assign m_axis_tuser_o = empty;

endmodule
